// ===== rtl/oar_pkg.sv =====
// Shared types, constants and command/status structs of the operand address resolver.
package oar_pkg;

    // Memory geometry: addresses alias above ADDR_BITS
    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    // Channel widths
    localparam int S_DATA_W = 56;
    localparam int S_USER_W = 5;
    localparam int M_DATA_W = 24;

    // Addressing codes carried in s_tuser[4:1]
    typedef enum logic [3:0] {
        AM_IMM  = 4'd0,
        AM_ZP   = 4'd1,
        AM_ZPX  = 4'd2,
        AM_ZPY  = 4'd3,
        AM_ABS  = 4'd4,
        AM_ABSX = 4'd5,
        AM_ABSY = 4'd6,
        AM_IND  = 4'd7,
        AM_INDX = 4'd8,
        AM_INDY = 4'd9,
        AM_REL  = 4'd10,
        AM_IMPL = 4'd11,
        AM_ACC  = 4'd12
    } addr_mode_t;

    // Item class as seen by the controller
    typedef enum logic [1:0] {
        K_LOAD,
        K_DIRECT,
        K_PTR,
        K_NONE
    } kind_t;

    // Source of the memory read address
    typedef enum logic [1:0] {
        RD_EA,
        RD_PTR_LO,
        RD_PTR_HI,
        RD_PTR_EA
    } rd_sel_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PTR_LO,
        S_PTR_HI,
        S_PTR_DATA,
        S_DATA,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    mem_we;
        logic    mem_re;
        rd_sel_t rd_sel;
        logic    latch_plo;
        logic    latch_ea;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  out_free;
    } status_t;

endpackage

// ===== rtl/operand_address_resolver_unit.sv =====
// Top level of the operand address resolver: controller, datapath and checks.
// A load item (mode 0) writes one byte into the internal 64 KiB memory and is
// done in the cycle it is accepted. A resolve item (mode 1) yields one result:
// immediate, relative, implied and accumulator present it with no memory
// read; zero page and absolute modes first read the data byte; indirect,
// (zp,x) and (zp),y read the pointer low byte, pointer high byte and data
// byte, which the single-port memory with its registered read port returns
// one after another. The result sits in an output register, so the next
// item is taken while it waits; a new result waits only if the previous one
// has not been transferred yet. Memory bytes that were never written read as
// unknown.
module operand_address_resolver_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [oar_pkg::S_DATA_W-1:0]  s_tdata,  // [7:0] operand_lo, [15:8] operand_hi,
                                                    // [23:16] index_x, [31:24] index_y,
                                                    // [47:32] load_address, [55:48] load_data
    input  logic [oar_pkg::S_USER_W-1:0]  s_tuser,  // [0] mode, [4:1] addressing
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [oar_pkg::M_DATA_W-1:0]  m_tdata,  // [15:0] effective_address,
                                                    // [23:16] operand_value
    output logic                          m_tuser   // [0] address_valid
);

    oar_pkg::cmd_t    cmd;
    oar_pkg::status_t status;

    oar_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    oar_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Never overwrite a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result register overwritten before transfer");

    // Single memory port: never read and write together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_we && cmd.mem_re))
        else $error("memory read and write in the same cycle");

    // Memory reads happen only while an item is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_re |-> !s_tready)
        else $error("memory read while accepting input");

    // A result is never loaded twice in a row
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !$past(cmd.load_out))
        else $error("result produced twice for one item");

endmodule

// ===== rtl/oar_datapath.sv =====
// Datapath of the operand address resolver: item registers, byte memory and result register.
module oar_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [oar_pkg::S_DATA_W-1:0]  s_tdata,  // operand_lo, operand_hi, index_x, index_y,
                                                    // load_address, load_data
    input  logic [oar_pkg::S_USER_W-1:0]  s_tuser,  // mode, addressing
    input  oar_pkg::cmd_t                 cmd,
    output oar_pkg::status_t              status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [oar_pkg::M_DATA_W-1:0]  m_tdata,  // effective_address, operand_value
    output logic                          m_tuser   // address_valid
);

    // Input fields
    logic                in_mode;
    oar_pkg::addr_mode_t in_am;
    logic [7:0]          in_lo;
    logic [7:0]          in_hi;
    logic [7:0]          in_x;
    logic [7:0]          in_y;
    logic [15:0]         in_ld_addr;
    logic [7:0]          in_ld_data;

    assign in_mode    = s_tuser[0];
    assign in_am      = oar_pkg::addr_mode_t'(s_tuser[4:1]);
    assign in_lo      = s_tdata[7:0];
    assign in_hi      = s_tdata[15:8];
    assign in_x       = s_tdata[23:16];
    assign in_y       = s_tdata[31:24];
    assign in_ld_addr = s_tdata[47:32];
    assign in_ld_data = s_tdata[55:48];

    // Item registers
    oar_pkg::addr_mode_t am_reg;
    logic [7:0]          lo_reg;
    logic [7:0]          y_reg;
    logic [15:0]         ptr_reg;
    logic [15:0]         ea_reg;
    logic [7:0]          plo_reg;
    logic [7:0]          rdata_reg;

    // Byte memory
    logic [7:0] mem [oar_pkg::MEM_DEPTH];

    // Result register
    logic        m_tvalid_reg;
    logic [15:0] out_ea_reg;
    logic [7:0]  out_val_reg;
    logic        out_av_reg;

    // Address arithmetic on the incoming item
    logic [15:0] abs16;
    logic [7:0]  zp_x;
    logic [7:0]  zp_y;
    logic [15:0] direct_ea;
    logic [15:0] ptr_base;

    // Pointer and memory read addresses
    logic [15:0] ptr_hi_addr;
    logic [15:0] ptr_ea;
    logic [15:0] rd_addr;

    assign abs16 = {in_hi, in_lo};
    assign zp_x  = in_lo + in_x;
    assign zp_y  = in_lo + in_y;

    always_comb
    begin
        direct_ea = 16'h0000;
        ptr_base  = 16'h0000;
        case (in_am)
            oar_pkg::AM_ZP:   direct_ea = {8'h00, in_lo};
            oar_pkg::AM_ZPX:  direct_ea = {8'h00, zp_x};
            oar_pkg::AM_ZPY:  direct_ea = {8'h00, zp_y};
            oar_pkg::AM_ABS:  direct_ea = abs16;
            oar_pkg::AM_ABSX: direct_ea = abs16 + {8'h00, in_x};
            oar_pkg::AM_ABSY: direct_ea = abs16 + {8'h00, in_y};
            oar_pkg::AM_IND:  ptr_base  = abs16;
            oar_pkg::AM_INDX: ptr_base  = {8'h00, zp_x};
            oar_pkg::AM_INDY: ptr_base  = {8'h00, in_lo};
            default:          direct_ea = 16'h0000;
        endcase
    end

    // Classify the offered item for the controller
    always_comb
    begin
        status.out_free = !m_tvalid_reg || m_tready;
        if (!in_mode)
        begin
            status.kind = oar_pkg::K_LOAD;
        end
        else
        begin
            case (in_am)
                oar_pkg::AM_ZP, oar_pkg::AM_ZPX, oar_pkg::AM_ZPY,
                oar_pkg::AM_ABS, oar_pkg::AM_ABSX, oar_pkg::AM_ABSY:
                    status.kind = oar_pkg::K_DIRECT;
                oar_pkg::AM_IND, oar_pkg::AM_INDX, oar_pkg::AM_INDY:
                    status.kind = oar_pkg::K_PTR;
                default:
                    status.kind = oar_pkg::K_NONE;
            endcase
        end
    end

    // Capture the item; pointer modes overwrite the address later
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            am_reg  <= in_am;
            lo_reg  <= in_lo;
            y_reg   <= in_y;
            ptr_reg <= ptr_base;
        end
        if (cmd.capture)
        begin
            ea_reg <= direct_ea;
        end
        else if (cmd.latch_ea)
        begin
            ea_reg <= ptr_ea;
        end
        if (cmd.latch_plo)
        begin
            plo_reg <= rdata_reg;
        end
    end

    // Pointer high byte: zero-page pointers wrap in page zero
    assign ptr_hi_addr = (am_reg == oar_pkg::AM_IND) ? (ptr_reg + 16'd1)
                                                     : {8'h00, ptr_reg[7:0] + 8'd1};
    assign ptr_ea = {rdata_reg, plo_reg}
                  + ((am_reg == oar_pkg::AM_INDY) ? {8'h00, y_reg} : 16'h0000);

    always_comb
    begin
        case (cmd.rd_sel)
            oar_pkg::RD_PTR_LO: rd_addr = ptr_reg;
            oar_pkg::RD_PTR_HI: rd_addr = ptr_hi_addr;
            oar_pkg::RD_PTR_EA: rd_addr = ptr_ea;
            default:            rd_addr = ea_reg;
        endcase
    end

    // Single-port memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[in_ld_addr[oar_pkg::ADDR_BITS-1:0]] <= in_ld_data;
        end
        else if (cmd.mem_re)
        begin
            rdata_reg <= mem[rd_addr[oar_pkg::ADDR_BITS-1:0]];
        end
    end

    // Form the result
    logic [7:0] res_val;
    logic       res_av;

    always_comb
    begin
        case (am_reg)
            oar_pkg::AM_IMM, oar_pkg::AM_REL:
            begin
                res_val = lo_reg;
                res_av  = 1'b0;
            end
            oar_pkg::AM_ZP, oar_pkg::AM_ZPX, oar_pkg::AM_ZPY,
            oar_pkg::AM_ABS, oar_pkg::AM_ABSX, oar_pkg::AM_ABSY,
            oar_pkg::AM_INDX, oar_pkg::AM_INDY:
            begin
                res_val = rdata_reg;
                res_av  = 1'b1;
            end
            oar_pkg::AM_IND:
            begin
                res_val = 8'h00;
                res_av  = 1'b1;
            end
            default:
            begin
                res_val = 8'h00;
                res_av  = 1'b0;
            end
        endcase
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_ea_reg  <= ea_reg;
            out_val_reg <= res_val;
            out_av_reg  <= res_av;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_val_reg, out_ea_reg};
    assign m_tuser  = out_av_reg;

endmodule

// ===== rtl/oar_controller.sv =====
// Controller state machine of the operand address resolver.
module oar_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  oar_pkg::status_t   status,
    output oar_pkg::cmd_t      cmd
);

    oar_pkg::state_t state_reg;
    oar_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oar_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oar_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (status.kind)
                        oar_pkg::K_LOAD:   state_next = oar_pkg::S_IDLE;
                        oar_pkg::K_DIRECT: state_next = oar_pkg::S_DATA;
                        oar_pkg::K_PTR:    state_next = oar_pkg::S_PTR_LO;
                        default:           state_next = oar_pkg::S_RESULT;
                    endcase
                end
            end
            oar_pkg::S_PTR_LO:   state_next = oar_pkg::S_PTR_HI;
            oar_pkg::S_PTR_HI:   state_next = oar_pkg::S_PTR_DATA;
            oar_pkg::S_PTR_DATA: state_next = oar_pkg::S_RESULT;
            oar_pkg::S_DATA:     state_next = oar_pkg::S_RESULT;
            oar_pkg::S_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = oar_pkg::S_IDLE;
                end
            end
            default:             state_next = oar_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        s_tready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.mem_we    = 1'b0;
        cmd.mem_re    = 1'b0;
        cmd.rd_sel    = oar_pkg::RD_EA;
        cmd.latch_plo = 1'b0;
        cmd.latch_ea  = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            oar_pkg::S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                cmd.mem_we  = s_tvalid && (status.kind == oar_pkg::K_LOAD);
            end
            oar_pkg::S_PTR_LO:
            begin
                cmd.mem_re = 1'b1;
                cmd.rd_sel = oar_pkg::RD_PTR_LO;
            end
            oar_pkg::S_PTR_HI:
            begin
                cmd.mem_re    = 1'b1;
                cmd.rd_sel    = oar_pkg::RD_PTR_HI;
                cmd.latch_plo = 1'b1;
            end
            oar_pkg::S_PTR_DATA:
            begin
                cmd.mem_re   = 1'b1;
                cmd.rd_sel   = oar_pkg::RD_PTR_EA;
                cmd.latch_ea = 1'b1;
            end
            oar_pkg::S_DATA:
            begin
                cmd.mem_re = 1'b1;
                cmd.rd_sel = oar_pkg::RD_EA;
            end
            oar_pkg::S_RESULT:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sim/tb_operand_address_resolver_unit.sv =====
// Self-checking testbench for the operand address resolver: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_operand_address_resolver_unit;

    // Addressing codes outside the defined set; the block treats them as implied
    localparam logic [3:0] AM_SPARE_FIRST = 4'd13;
    localparam logic [3:0] AM_SPARE_LAST  = 4'd15;

    localparam logic [15:0] MEM_MASK    = 16'(oar_pkg::MEM_DEPTH - 1);
    localparam int          RANDOM_ITEMS = 1050;
    localparam int          DRAIN_LIMIT  = 20000;
    localparam int          SETTLE_CYCLES = 16;

    typedef struct {
        logic        mode;
        logic [3:0]  am;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] load_addr;
        logic [7:0]  load_data;
    } op_item_t;

    typedef struct {
        logic [15:0] ea;
        logic [7:0]  val;
        logic        valid;
    } resolved_t;

    typedef struct {
        op_item_t  item;
        bit        typed;
        resolved_t want;
    } table_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [oar_pkg::S_DATA_W-1:0]  s_tdata;
    logic [oar_pkg::S_USER_W-1:0]  s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [oar_pkg::M_DATA_W-1:0]  m_tdata;
    logic                          m_tuser;

    // Mirror of the block's byte memory and which entries hold a written byte
    logic [7:0]   shadow_mem [0:oar_pkg::MEM_DEPTH-1];
    bit           shadow_written [0:oar_pkg::MEM_DEPTH-1];
    resolved_t    pending_results [$];
    table_row_t   directed_rows [$];
    int           mismatch_count = 0;
    int           items_sent = 0;
    bit           steady_in = 1'b0;
    bit           steady_out = 1'b0;

    operand_address_resolver_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Print one line per mismatch and count it
    task automatic flag_mismatch(string what, int got, int want);
        $display("MISMATCH at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [7:0] peek(logic [15:0] addr);
        return shadow_mem[addr & MEM_MASK];
    endfunction

    // Two-byte pointer from zero page; the high byte wraps within the page
    function automatic logic [15:0] zp_pointer(logic [7:0] zp);
        logic [7:0] nxt;
        nxt = zp + 8'd1;
        return {peek({8'h00, nxt}), peek({8'h00, zp})};
    endfunction

    // Predict the result of a resolve item from the mirrored memory
    function automatic resolved_t resolve_operand(op_item_t it);
        logic [15:0] abs16;
        logic [7:0]  zp;
        resolved_t   r;
        abs16 = {it.hi, it.lo};
        r.ea = 16'h0000;
        r.val = 8'h00;
        r.valid = 1'b0;
        case (it.am)
            oar_pkg::AM_IMM, oar_pkg::AM_REL:
            begin
                r.val = it.lo;
            end
            oar_pkg::AM_ZP:
            begin
                r.ea = {8'h00, it.lo};
                r.valid = 1'b1;
            end
            oar_pkg::AM_ZPX:
            begin
                zp = it.lo + it.x;
                r.ea = {8'h00, zp};
                r.valid = 1'b1;
            end
            oar_pkg::AM_ZPY:
            begin
                zp = it.lo + it.y;
                r.ea = {8'h00, zp};
                r.valid = 1'b1;
            end
            oar_pkg::AM_ABS:
            begin
                r.ea = abs16;
                r.valid = 1'b1;
            end
            oar_pkg::AM_ABSX:
            begin
                r.ea = abs16 + {8'h00, it.x};
                r.valid = 1'b1;
            end
            oar_pkg::AM_ABSY:
            begin
                r.ea = abs16 + {8'h00, it.y};
                r.valid = 1'b1;
            end
            oar_pkg::AM_IND:
            begin
                // High pointer byte comes from the next address, no page wrap
                r.ea = {peek(abs16 + 16'd1), peek(abs16)};
                r.valid = 1'b1;
            end
            oar_pkg::AM_INDX:
            begin
                zp = it.lo + it.x;
                r.ea = zp_pointer(zp);
                r.valid = 1'b1;
            end
            oar_pkg::AM_INDY:
            begin
                r.ea = zp_pointer(it.lo) + {8'h00, it.y};
                r.valid = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (r.valid && it.am != oar_pkg::AM_IND)
        begin
            r.val = peek(r.ea);
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 7));
            1: return 8'($urandom_range(248, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic op_item_t random_item();
        op_item_t it;
        it.mode = 1'($urandom);
        it.am = 4'($urandom_range(0, 15));
        it.lo = 8'($urandom);
        it.hi = 8'($urandom);
        it.x = 8'($urandom);
        it.y = 8'($urandom);
        it.load_addr = 16'($urandom);
        it.load_data = 8'($urandom);
        return it;
    endfunction

    // Drive one item, wait for its transfer, then update the mirror or queue the result
    task automatic send_item(op_item_t it, bit typed, resolved_t want);
        int gap;
        logic [15:0] idx;
        bit accepted;
        gap = steady_in ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {it.load_data, it.load_addr, it.y, it.x, it.hi, it.lo};
        s_tuser <= {it.am, it.mode};
        // Sample ready mid-cycle; it only changes at the rising edge
        do
        begin
            @(negedge clk);
            accepted = s_tready;
            @(posedge clk);
        end
        while (!accepted);
        items_sent++;
        if (!it.mode)
        begin
            idx = it.load_addr & MEM_MASK;
            shadow_mem[idx] = it.load_data;
            shadow_written[idx] = 1'b1;
        end
        else
        begin
            pending_results.push_back(typed ? want : resolve_operand(it));
        end
    endtask

    // Write a random byte to an address that has not been written yet
    task automatic fill_byte(logic [15:0] addr);
        op_item_t  it;
        resolved_t none;
        none = '{16'h0000, 8'h00, 1'b0};
        if (!shadow_written[addr & MEM_MASK])
        begin
            it = random_item();
            it.mode = 1'b0;
            it.load_addr = addr;
            send_item(it, 1'b0, none);
        end
    endtask

    // Make sure every byte a resolve item reads has been written first
    task automatic prime_reads(op_item_t it);
        logic [15:0] abs16;
        logic [7:0]  zp;
        resolved_t   r;
        abs16 = {it.hi, it.lo};
        case (it.am)
            oar_pkg::AM_IND:
            begin
                fill_byte(abs16);
                fill_byte(abs16 + 16'd1);
            end
            oar_pkg::AM_INDX:
            begin
                zp = it.lo + it.x;
                fill_byte({8'h00, zp});
                zp = zp + 8'd1;
                fill_byte({8'h00, zp});
            end
            oar_pkg::AM_INDY:
            begin
                zp = it.lo;
                fill_byte({8'h00, zp});
                zp = zp + 8'd1;
                fill_byte({8'h00, zp});
            end
            default:
            begin
            end
        endcase
        r = resolve_operand(it);
        if (r.valid && it.am != oar_pkg::AM_IND)
        begin
            fill_byte(r.ea);
        end
    endtask

    task automatic add_row(logic mode, logic [3:0] am, logic [7:0] lo, logic [7:0] hi,
                           logic [7:0] x, logic [7:0] y, logic [15:0] la, logic [7:0] ld,
                           bit typed, logic [15:0] ea, logic [7:0] val, logic av);
        table_row_t row;
        row.item = '{mode, am, lo, hi, x, y, la, ld};
        row.typed = typed;
        row.want = '{ea, val, av};
        directed_rows.push_back(row);
    endtask

    // Compare each result transfer with the oldest expectation; the handshake
    // signals only change at the rising edge, so mid-cycle values are the ones
    // seen by the next edge
    always @(negedge clk)
    begin
        resolved_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch("result with nothing expected", m_tdata, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.ea)
                    flag_mismatch("effective_address", m_tdata[15:0], want.ea);
                if (m_tdata[23:16] !== want.val)
                    flag_mismatch("operand_value", m_tdata[23:16], want.val);
                if (m_tuser !== want.valid)
                    flag_mismatch("address_valid", m_tuser, want.valid);
            end
        end
    end

    // Result side: stall a random number of cycles before each transfer
    initial
    begin
        int gap;
        int taken;
        bit seen;
        taken = 0;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
                steady_out = ($urandom_range(0, 3) == 0);
            gap = steady_out ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                seen = m_tvalid;
                @(posedge clk);
            end
            while (!seen);
            taken++;
        end
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        op_item_t  it;
        resolved_t none;
        int        waited;
        int        next_toggle;
        none = '{16'h0000, 8'h00, 1'b0};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Loads: extreme addresses and data, pointers across page and memory ends
        add_row(1'b0, oar_pkg::AM_IMM, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0010, 8'hFF,
                0, 0, 0, 0);
        add_row(1'b0, oar_pkg::AM_ACC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h00FF, 8'h34,
                0, 0, 0, 0);
        add_row(1'b0, oar_pkg::AM_ZP, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h12,
                0, 0, 0, 0);
        add_row(1'b0, oar_pkg::AM_IND, 8'h00, 8'h00, 8'h00, 8'h00, 16'h1234, 8'h5A,
                0, 0, 0, 0);
        add_row(1'b0, oar_pkg::AM_ABS, 8'h00, 8'h00, 8'h00, 8'h00, 16'h1333, 8'hC3,
                0, 0, 0, 0);
        add_row(1'b0, oar_pkg::AM_INDY, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF, 8'hEE,
                0, 0, 0, 0);
        // Operand-only and address-free modes, spare codes
        add_row(1'b1, oar_pkg::AM_IMM, 8'hFF, 8'h00, 8'h00, 8'h00, 16'hFFFF, 8'hFF,
                1, 16'h0000, 8'hFF, 0);
        add_row(1'b1, oar_pkg::AM_IMM, 8'h00, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 8'h00,
                1, 16'h0000, 8'h00, 0);
        add_row(1'b1, oar_pkg::AM_REL, 8'h80, 8'h12, 8'h00, 8'h00, 16'h0000, 8'h00,
                1, 16'h0000, 8'h80, 0);
        add_row(1'b1, oar_pkg::AM_IMPL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 8'h00,
                1, 16'h0000, 8'h00, 0);
        add_row(1'b1, oar_pkg::AM_ACC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 8'h00,
                1, 16'h0000, 8'h00, 0);
        add_row(1'b1, AM_SPARE_FIRST, 8'h10, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00,
                1, 16'h0000, 8'h00, 0);
        add_row(1'b1, AM_SPARE_LAST, 8'h10, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00,
                1, 16'h0000, 8'h00, 0);
        // Zero page with index wrap, absolute with 16-bit wrap and carry
        add_row(1'b1, oar_pkg::AM_ZP, 8'h10, 8'hFF, 8'h00, 8'h00, 16'h0000, 8'h00,
                1, 16'h0010, 8'hFF, 1);
        add_row(1'b1, oar_pkg::AM_ZPX, 8'h20, 8'h00, 8'hF0, 8'h00, 16'h0000, 8'h00,
                1, 16'h0010, 8'hFF, 1);
        add_row(1'b1, oar_pkg::AM_ZPY, 8'h11, 8'h00, 8'h00, 8'hFF, 16'h0000, 8'h00,
                1, 16'h0010, 8'hFF, 1);
        add_row(1'b1, oar_pkg::AM_ABS, 8'h34, 8'h12, 8'h00, 8'h00, 16'h0000, 8'h00,
                1, 16'h1234, 8'h5A, 1);
        add_row(1'b1, oar_pkg::AM_ABSX, 8'hFF, 8'hFF, 8'h11, 8'h00, 16'h0000, 8'h00,
                1, 16'h0010, 8'hFF, 1);
        add_row(1'b1, oar_pkg::AM_ABSY, 8'h34, 8'h12, 8'h00, 8'hFF, 16'h0000, 8'h00,
                1, 16'h1333, 8'hC3, 1);
        // Pointer modes: pointer across the top of memory and across zero page end
        add_row(1'b1, oar_pkg::AM_IND, 8'hFF, 8'hFF, 8'h00, 8'h00, 16'h0000, 8'h00,
                0, 0, 0, 0);
        add_row(1'b1, oar_pkg::AM_INDX, 8'h0F, 8'h00, 8'hF0, 8'h00, 16'h0000, 8'h00,
                0, 0, 0, 0);
        add_row(1'b1, oar_pkg::AM_INDY, 8'hFF, 8'h00, 8'h00, 8'hFF, 16'h0000, 8'h00,
                0, 0, 0, 0);
        add_row(1'b1, oar_pkg::AM_INDY, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00,
                0, 0, 0, 0);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random traffic: mostly resolves with their reads primed, some plain loads
        next_toggle = items_sent;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= next_toggle)
            begin
                steady_in = ($urandom_range(0, 3) == 0);
                next_toggle = items_sent + 40;
            end
            it = random_item();
            if ($urandom_range(0, 4) == 0)
            begin
                it.mode = 1'b0;
                if ($urandom_range(0, 1) == 1)
                    it.load_addr = {pick_byte(), pick_byte()};
                send_item(it, 1'b0, none);
            end
            else
            begin
                it.mode = 1'b1;
                it.am = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
                                                   : 4'($urandom_range(0, 12));
                it.lo = pick_byte();
                it.hi = pick_byte();
                it.x = pick_byte();
                it.y = pick_byte();
                prime_reads(it);
                send_item(it, 1'b0, none);
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
            flag_mismatch("results never delivered", pending_results.size(), 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
